// ----- rtl/uic_pkg.sv -----
// ----------------------------------------------------------------------------
// uic_pkg: shared types and constants for the universal integer codec
// Field widths, configuration codes, decoder phases and the result beat.
// ----------------------------------------------------------------------------
package uic_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int VALUE_IN_W      = 32;
    localparam int VALUE_OUT_W     = 32;
    localparam int CODE_WORD_W     = 64;
    localparam int CODE_LEN_W      = 7;
    localparam int RUN_W           = 6;
    localparam int UNARY_MAX       = 63;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 2'd1;

    // code modes; the unused code behaves as gamma
    localparam logic [1:0] MODE_UNARY = 2'd0;
    localparam logic [1:0] MODE_GAMMA = 2'd1;
    localparam logic [1:0] MODE_DELTA = 2'd2;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef enum logic [1:0] {
        PH_ZERO    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DLEN    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CODE_WORD_W-1:0] code_word;
        logic [CODE_LEN_W-1:0]  code_length;
        logic [VALUE_OUT_W-1:0] value_out;
        logic                   value_valid;
        logic                   error_flag;
    } result_t;

endpackage

// ----- rtl/uic_if.sv -----
// ----------------------------------------------------------------------------
// uic channel interfaces
// Valid/ready channels for input items and result beats of the codec.
// ----------------------------------------------------------------------------
interface uic_item_if
    import uic_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_IN_W-1:0] value_in;
    logic                  code_bit;

    modport source (output valid, value_in, code_bit, input ready);
    modport sink   (input valid, value_in, code_bit, output ready);
endinterface

interface uic_result_if
    import uic_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CODE_WORD_W-1:0] code_word;
    logic [CODE_LEN_W-1:0]  code_length;
    logic [VALUE_OUT_W-1:0] value_out;
    logic                   value_valid;
    logic                   error_flag;

    modport source (output valid, code_word, code_length, value_out, value_valid,
                    error_flag, input ready);
    modport sink   (input valid, code_word, code_length, value_out, value_valid,
                    error_flag, output ready);
endinterface

// ----- rtl/universal_integer_codec_unit.sv -----
// ----------------------------------------------------------------------------
// universal_integer_codec_unit: unary / Elias gamma / Elias delta codec
// Encodes one value per beat into a right-aligned code word, or decodes one
// code bit per beat into values.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock and keeps that rate as long as the result
// side takes its beats. Each beat passes an input register and then a result
// register. In encode direction every input beat yields one result beat: a
// priority encoder finds the bit length of the value and, in delta mode, a
// pair of shifts builds the code word. In decode direction every input beat
// is one code bit; a result beat comes out only when a code word ends or an
// error is found, and the bit serial decoder state (phase, zero run,
// remaining bits, accumulator) advances once per bit. Writing code_mode or
// direction clears the decoder; write them only while the unit is idle. Zero
// values in gamma/delta, unary values above 63 and overlong zero runs or
// delta lengths return a beat with error_flag set.
// ----------------------------------------------------------------------------
module universal_integer_codec_unit
    import uic_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    uic_item_if.sink               item,
    uic_result_if.source           result
);

    // bit length of values up to VALUE_WIDTH bits
    localparam int LEN_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [RUN_W-1:0] LIMIT_UNARY = RUN_W'(UNARY_MAX);
    localparam logic [RUN_W-1:0] LIMIT_GAMMA = RUN_W'(VALUE_WIDTH - 1);
    localparam logic [RUN_W-1:0] LIMIT_DELTA = RUN_W'(LEN_W - 1);

    function automatic logic [LEN_W-1:0] bit_len(input logic [VALUE_WIDTH-1:0] v);
        logic [LEN_W-1:0] r;
        r = '0;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (v[i])
            begin
                r = LEN_W'(i + 1);
            end
        end
        return r;
    endfunction

    // configuration
    logic [1:0] code_mode_reg;
    logic       direction_reg;
    logic       cfg_hit;

    // input stage
    logic                   item_valid_reg;
    logic [VALUE_WIDTH-1:0] item_value_reg;
    logic                   item_bit_reg;

    // decoder state
    phase_t                 phase_reg, phase_next;
    logic [RUN_W-1:0]       zero_run_reg, zero_run_next;
    logic [RUN_W-1:0]       bits_rem_reg, bits_rem_next;
    logic [VALUE_WIDTH-1:0] accum_reg, accum_next;

    // result stage
    logic    res_valid_reg;
    result_t res_reg;

    logic    produce;
    logic    advance;
    logic    take_item;
    result_t enc_res, dec_res, res_next;
    logic    dec_produce;

    assign cfg_hit = cfg_we && (cfg_index == CFG_CODE_MODE || cfg_index == CFG_DIRECTION);

    logic is_unary, is_delta;
    assign is_unary = (code_mode_reg == MODE_UNARY);
    assign is_delta = (code_mode_reg == MODE_DELTA);

    // ---------------- handshake ----------------
    // Beats that produce no result drain without needing the result register.
    assign produce   = (direction_reg == DIR_ENCODE) || dec_produce;
    assign advance   = item_valid_reg && (!produce || !res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign take_item = item.valid && item.ready;

    // ---------------- encoder ----------------
    logic [VALUE_WIDTH-1:0] enc_n;
    logic [LEN_W-1:0]       enc_len, enc_ll, enc_sh;

    assign enc_n   = item_value_reg;
    assign enc_len = bit_len(enc_n);
    assign enc_ll  = bit_len(VALUE_WIDTH'(enc_len));
    assign enc_sh  = enc_len - LEN_W'(1);

    always_comb
    begin
        enc_res = '0;
        if (is_unary)
        begin
            if (enc_n > VALUE_WIDTH'(UNARY_MAX))
            begin
                enc_res.error_flag = 1'b1;
            end
            else
            begin
                enc_res.code_word   = CODE_WORD_W'(1);
                enc_res.code_length = CODE_LEN_W'(enc_n) + CODE_LEN_W'(1);
            end
        end
        else if (enc_len == '0)
        begin
            enc_res.error_flag = 1'b1;
        end
        else if (is_delta)
        begin
            // gamma(len) followed by the value with its leading one dropped
            enc_res.code_word   = (CODE_WORD_W'(enc_len) << enc_sh)
                                | (CODE_WORD_W'(enc_n)
                                   & ((CODE_WORD_W'(1) << enc_sh) - CODE_WORD_W'(1)));
            enc_res.code_length = CODE_LEN_W'(enc_ll) + CODE_LEN_W'(enc_ll)
                                + CODE_LEN_W'(enc_len) - CODE_LEN_W'(2);
        end
        else
        begin
            enc_res.code_word   = CODE_WORD_W'(enc_n);
            enc_res.code_length = CODE_LEN_W'(enc_len) + CODE_LEN_W'(enc_len)
                                - CODE_LEN_W'(1);
        end
    end

    // ---------------- decoder ----------------
    logic [VALUE_WIDTH-1:0] dec_shift;
    logic [RUN_W-1:0]       rem_dec, run_limit;
    logic                   in_body, body_done, dlen_over, dlen_one, run_over;

    assign dec_shift = {accum_reg[VALUE_WIDTH-2:0], item_bit_reg};
    assign rem_dec   = bits_rem_reg - RUN_W'(1);
    assign in_body   = (phase_reg == PH_PAYLOAD) || (phase_reg == PH_DLEN);
    assign body_done = (rem_dec == '0);
    assign dlen_over = (dec_shift > VALUE_WIDTH'(VALUE_WIDTH));
    assign dlen_one  = (dec_shift == VALUE_WIDTH'(1));
    assign run_limit = is_unary ? LIMIT_UNARY : (is_delta ? LIMIT_DELTA : LIMIT_GAMMA);
    assign run_over  = !item_bit_reg && (zero_run_reg >= run_limit);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                if (body_done)
                begin
                    phase_next = PH_ZERO;
                end
            end
            PH_DLEN:
            begin
                if (body_done)
                begin
                    phase_next = (dlen_over || dlen_one) ? PH_ZERO : PH_PAYLOAD;
                end
            end
            default:
            begin
                if (item_bit_reg && !is_unary && zero_run_reg != '0)
                begin
                    phase_next = is_delta ? PH_DLEN : PH_PAYLOAD;
                end
            end
        endcase
    end

    // decoder datapath and result
    always_comb
    begin
        dec_produce   = 1'b0;
        dec_res       = '0;
        zero_run_next = zero_run_reg;
        bits_rem_next = bits_rem_reg;
        accum_next    = accum_reg;
        case (phase_reg) inside
            PH_PAYLOAD, PH_DLEN:
            begin
                accum_next    = dec_shift;
                bits_rem_next = rem_dec;
                if (body_done)
                begin
                    if (phase_reg == PH_PAYLOAD)
                    begin
                        dec_produce          = 1'b1;
                        dec_res.value_out    = VALUE_OUT_W'(dec_shift);
                        dec_res.value_valid  = 1'b1;
                    end
                    else if (dlen_over)
                    begin
                        dec_produce        = 1'b1;
                        dec_res.error_flag = 1'b1;
                    end
                    else if (dlen_one)
                    begin
                        dec_produce         = 1'b1;
                        dec_res.value_out   = VALUE_OUT_W'(1);
                        dec_res.value_valid = 1'b1;
                    end
                    else
                    begin
                        // length field done: load the payload count
                        accum_next    = VALUE_WIDTH'(1);
                        bits_rem_next = dec_shift[RUN_W-1:0] - RUN_W'(1);
                    end
                end
            end
            default:
            begin
                if (!item_bit_reg)
                begin
                    if (run_over)
                    begin
                        dec_produce        = 1'b1;
                        dec_res.error_flag = 1'b1;
                    end
                    else
                    begin
                        zero_run_next = zero_run_reg + RUN_W'(1);
                    end
                end
                else if (is_unary)
                begin
                    dec_produce         = 1'b1;
                    dec_res.value_out   = VALUE_OUT_W'(zero_run_reg);
                    dec_res.value_valid = 1'b1;
                end
                else if (zero_run_reg == '0)
                begin
                    dec_produce         = 1'b1;
                    dec_res.value_out   = VALUE_OUT_W'(1);
                    dec_res.value_valid = 1'b1;
                end
                else
                begin
                    accum_next    = VALUE_WIDTH'(1);
                    bits_rem_next = zero_run_reg;
                    zero_run_next = '0;
                end
            end
        endcase
        // any completed code word or error drops the decoder back to idle
        if (dec_produce)
        begin
            zero_run_next = '0;
            bits_rem_next = '0;
            accum_next    = '0;
        end
    end

    assign res_next = (direction_reg == DIR_ENCODE) ? enc_res : dec_res;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_mode_reg  <= MODE_GAMMA;
            direction_reg  <= DIR_ENCODE;
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            phase_reg      <= PH_ZERO;
            zero_run_reg   <= '0;
            bits_rem_reg   <= '0;
            accum_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CODE_MODE: code_mode_reg <= cfg_data;
                    CFG_DIRECTION: direction_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            // hold the input register until its beat moves on
            if (take_item)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance && produce)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cfg_hit)
            begin
                phase_reg    <= PH_ZERO;
                zero_run_reg <= '0;
                bits_rem_reg <= '0;
                accum_reg    <= '0;
            end
            else if (advance && direction_reg == DIR_DECODE)
            begin
                phase_reg    <= dec_produce ? PH_ZERO : phase_next;
                zero_run_reg <= zero_run_next;
                bits_rem_reg <= bits_rem_next;
                accum_reg    <= accum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_value_reg <= item.value_in[VALUE_WIDTH-1:0];
            item_bit_reg   <= item.code_bit;
        end
        if (advance && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.code_word   = res_reg.code_word;
    assign result.code_length = res_reg.code_length;
    assign result.value_out   = res_reg.value_out;
    assign result.value_valid = res_reg.value_valid;
    assign result.error_flag  = res_reg.error_flag;

    // ---------------- assertions ----------------
    a_dec_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.value_valid |-> res_reg.code_length == '0
                                               && !res_reg.error_flag)
        else $error("decoded value beat carries code bits or an error");

    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.error_flag |-> res_reg.code_length == '0
                                              && res_reg.value_out == '0)
        else $error("error beat carries payload");

    a_body_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_ZERO |-> zero_run_reg == '0 && bits_rem_reg != '0)
        else $error("decoder body phase with stale zero run or empty count");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> phase_reg == PH_ZERO && accum_reg == '0)
        else $error("configuration write did not clear the decoder");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result.ready |=> res_valid_reg && $stable(res_reg))
        else $error("result register changed under backpressure");

endmodule
